// File: src/hkc_pkg.sv
// Shared types and constants for the keepalive client table.
// Holds the item and result structs, action and status codes, default sizes.
// No dependencies.
`default_nettype none

package hkc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF       = 32;
    localparam int ACTION_W          = 3;
    localparam int CLIENT_ID_W       = 32;
    localparam int STATUS_W          = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REGISTER        = 3'd0,
        ACT_HELLO           = 3'd1,
        ACT_QUERY_ACTIVE    = 3'd2,
        ACT_QUERY_CONTAINED = 3'd3,
        ACT_TICK            = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [CLIENT_ID_W-1:0] client_id;
    } cmd_t;

    typedef struct packed {
        status_t status;
        logic    is_active;
        logic    is_present;
    } result_t;

endpackage

`default_nettype wire

// File: src/hkc_table.sv
// Client table: valid bits, ids and hello flags, matched in parallel.
// Applies one item per cycle and gives its result combinationally.
// Depends on hkc_pkg.
`default_nettype none

module hkc_table #(
    parameter int ENTRIES = 16,
    parameter int KEY_W   = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    input  wire logic [hkc_pkg::ACTION_W-1:0]     action,
    input  wire logic [KEY_W-1:0]                 key,
    output hkc_pkg::result_t                      resp
);
    import hkc_pkg::*;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] hello_reg, hello_next;
    logic [ENTRIES-1:0] before_reg, before_next;
    logic [KEY_W-1:0]   id_reg [ENTRIES];
    logic [ENTRIES-1:0] id_wr;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] match_oh;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] target;
    logic               hit;
    logic               full;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (id_reg[i] == key);
        end
    end

    assign match_oh = match & (~match + ENTRIES'(1));
    assign free_oh  = ~valid_reg & (valid_reg + ENTRIES'(1));
    assign hit      = |match;
    assign full     = &valid_reg;
    assign target   = hit ? match_oh : free_oh;

    always_comb
    begin
        valid_next  = valid_reg;
        hello_next  = hello_reg;
        before_next = before_reg;
        id_wr       = '0;
        resp        = '{status: ST_OK, is_active: 1'b0, is_present: 1'b0};
        if (cmd_valid)
        begin
            unique case (action) inside
                ACT_REGISTER:
                begin
                    if (!hit && full)
                    begin
                        resp.status = ST_TABLE_FULL;
                    end
                    else
                    begin
                        valid_next      = valid_reg | target;
                        hello_next      = hello_reg & ~target;
                        before_next     = before_reg & ~target;
                        id_wr           = target;
                        resp.is_present = 1'b1;
                    end
                end
                ACT_HELLO, ACT_QUERY_ACTIVE, ACT_QUERY_CONTAINED:
                begin
                    if (!hit)
                    begin
                        resp.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        resp.is_present = 1'b1;
                        if (action == ACT_HELLO)
                        begin
                            hello_next     = hello_reg | match_oh;
                            before_next    = before_reg | match_oh;
                            resp.is_active = 1'b1;
                        end
                        else
                        begin
                            resp.is_active = |(match_oh & before_reg);
                        end
                    end
                end
                ACT_TICK:
                begin
                    hello_next  = hello_reg & ~valid_reg;
                    before_next = before_reg & ~(valid_reg & ~hello_reg);
                    valid_next  = valid_reg & (hello_reg | before_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            hello_reg  <= '0;
            before_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            hello_reg  <= hello_next;
            before_reg <= before_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (id_wr[i])
            begin
                id_reg[i] <= key;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/hello_keepalive_client_table.sv
// Keepalive client table, top level: input register, table, result register.
// An accepted item is held in the input register, and its result is registered after the table.
// Throughput: one item per cycle; busy stays low.
// The result shows for one cycle with done high; the receiver cannot stall.
// Reset clears all valid bits and hello flags at once; ids need no reset.
// Depends on hkc_pkg and hkc_table.
`default_nettype none

module hello_keepalive_client_table #(
    parameter int TABLE_ENTRIES = hkc_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BITS       = hkc_pkg::ID_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire hkc_pkg::cmd_t cmd,
    output      logic          busy,
    output      logic          done,
    output hkc_pkg::result_t   result
);
    import hkc_pkg::*;

    localparam int KEY_W = (ID_BITS < CLIENT_ID_W) ? ID_BITS : CLIENT_ID_W;

    logic    cmd_valid_reg;
    cmd_t    cmd_reg;
    logic    done_reg;
    result_t result_reg;
    result_t resp;

    assign busy = 1'b0;

    hkc_table #(
        .ENTRIES (TABLE_ENTRIES),
        .KEY_W   (KEY_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid_reg),
        .action    (cmd_reg.action),
        .key       (cmd_reg.client_id[KEY_W-1:0]),
        .resp      (resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
            done_reg      <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        if (cmd_valid_reg)
        begin
            result_reg <= resp;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: tb/sv/hello_keepalive_client_table_test.sv
// Self-checking testbench for the keepalive client table (hello_keepalive_client_table).
// Drives commands through start/busy, predicts every result and checks it when done is high.
// Depends on hkc_pkg and the RTL of hello_keepalive_client_table.
`timescale 1ns / 1ps

module hello_keepalive_client_table_test;

    import hkc_pkg::*;

    localparam int SLOTS        = TABLE_ENTRIES_DEF;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_ITEMS  = 100;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

    typedef struct {
        cmd_t cmd;
        int   gap;
        bit   drain;
    } pending_cmd_t;

    logic    clk    = 1'b0;
    logic    rst_n  = 1'b0;
    logic    start  = 1'b0;
    cmd_t    cmd_in = '0;
    logic    busy;
    logic    done;
    result_t result;

    pending_cmd_t cmd_backlog[$];
    result_t      pending_results[$];

    bit                   slot_valid[SLOTS];
    logic [ID_BITS_DEF-1:0] slot_id[SLOTS];
    bit                   slot_hello[SLOTS];
    bit                   slot_hello_prev[SLOTS];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int gap_left       = 0;
    bit gap_loaded     = 1'b0;
    bit gaps_on        = 1'b1;

    logic [CLIENT_ID_W-1:0] id_pool[POOL_SIZE];

    hello_keepalive_client_table u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd_in),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int find_client(logic [CLIENT_ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[i] && slot_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic result_t apply_table_cmd(cmd_t c);
        result_t r;
        int      slot;
        r.status     = ST_OK;
        r.is_active  = 1'b0;
        r.is_present = 1'b0;
        slot         = -1;
        case (c.action)
            ACT_REGISTER:
            begin
                slot = find_client(c.client_id);
                if (slot < 0)
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                    begin
                        if (!slot_valid[i])
                            slot = i;
                    end
                end
                if (slot < 0)
                    r.status = ST_TABLE_FULL;
                else
                begin
                    slot_valid[slot]      = 1'b1;
                    slot_id[slot]         = c.client_id;
                    slot_hello[slot]      = 1'b0;
                    slot_hello_prev[slot] = 1'b0;
                    r.is_present          = 1'b1;
                end
            end
            ACT_HELLO, ACT_QUERY_ACTIVE, ACT_QUERY_CONTAINED:
            begin
                slot = find_client(c.client_id);
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    if (c.action == ACT_HELLO)
                    begin
                        slot_hello[slot]      = 1'b1;
                        slot_hello_prev[slot] = 1'b1;
                    end
                    r.is_present = 1'b1;
                    r.is_active  = slot_hello_prev[slot];
                end
            end
            ACT_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_valid[i])
                    begin
                        if (slot_hello[i])
                            slot_hello[i] = 1'b0;
                        else if (slot_hello_prev[i])
                            slot_hello_prev[i] = 1'b0;
                        else
                            slot_valid[i] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic queue_cmd(logic [ACTION_W-1:0] act, logic [CLIENT_ID_W-1:0] id,
                             bit drain);
        pending_cmd_t p;
        int           r;
        p.cmd.action    = act;
        p.cmd.client_id = id;
        p.drain         = drain;
        p.gap           = 0;
        if (gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                p.gap = 0;
            else if (r < 90)
                p.gap = $urandom_range(1, 3);
            else if (r < 98)
                p.gap = $urandom_range(4, 10);
            else
                p.gap = $urandom_range(20, 60);
        end
        cmd_backlog.push_back(p);
    endtask

    // Driver: record accepted items, then present the next one after its gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_loaded = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                pending_results.push_back(apply_table_cmd(cmd_in));
                void'(cmd_backlog.pop_front());
                gap_loaded = 1'b0;
            end
            if (!(start && busy))
            begin
                if (cmd_backlog.size() == 0)
                    start <= 1'b0;
                else
                begin
                    if (!gap_loaded)
                    begin
                        gap_left   = cmd_backlog[0].gap;
                        gap_loaded = 1'b1;
                    end
                    if (gap_left > 0)
                    begin
                        gap_left--;
                        start <= 1'b0;
                    end
                    else if (cmd_backlog[0].drain && pending_results.size() != 0)
                        start <= 1'b0;
                    else
                    begin
                        start  <= 1'b1;
                        cmd_in <= cmd_backlog[0].cmd;
                    end
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d is_active %0d is_present %0d",
                       result.status, result.is_active, result.is_present);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_count++;
                end
                if (result.is_active !== want.is_active)
                begin
                    $error("is_active: expected %0d, got %0d", want.is_active,
                           result.is_active);
                    mismatch_count++;
                end
                if (result.is_present !== want.is_present)
                begin
                    $error("is_present: expected %0d, got %0d", want.is_present,
                           result.is_present);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int                     mode;
        int                     r;
        logic [ACTION_W-1:0]    act;
        logic [CLIENT_ID_W-1:0] id;

        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i]      = 1'b0;
            slot_id[i]         = '0;
            slot_hello[i]      = 1'b0;
            slot_hello_prev[i] = 1'b0;
        end

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;

        // Directed: extremes, unknown ids, full table, re-arm, spare codes, aging.
        queue_cmd(ACT_REGISTER, 32'h0000_0000, 1'b0);
        queue_cmd(ACT_REGISTER, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_HELLO, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_QUERY_ACTIVE, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_QUERY_ACTIVE, 32'h0000_0000, 1'b0);
        queue_cmd(ACT_HELLO, 32'h0000_0005, 1'b0);
        queue_cmd(ACT_QUERY_CONTAINED, 32'h0000_0005, 1'b0);
        for (int i = 0; i < SLOTS - 2; i++)
            queue_cmd(ACT_REGISTER, 32'h1000_0000 + i, 1'b0);
        queue_cmd(ACT_REGISTER, 32'h5A5A_A5A5, 1'b0);
        queue_cmd(ACT_REGISTER, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_SPARE_LO, 32'h0000_0000, 1'b0);
        queue_cmd(ACT_SPARE_MID, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_SPARE_HI, 32'h1234_5678, 1'b0);
        queue_cmd(ACT_HELLO, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_TICK, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_QUERY_ACTIVE, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_TICK, 32'h0000_0000, 1'b0);
        queue_cmd(ACT_QUERY_ACTIVE, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_TICK, 32'h0000_0000, 1'b0);
        queue_cmd(ACT_QUERY_CONTAINED, 32'hFFFF_FFFF, 1'b0);

        // Random phases: balanced, register-heavy, tick-heavy; gaps on or off.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                mode    = $urandom_range(0, 2);
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            case (mode)
                1:       r = (r < 50) ? r / 2 : r;
                2:       r = (r < 30) ? 85 + r % 12 : r;
                default: r = r;
            endcase
            if (r < 25)
                act = ACT_REGISTER;
            else if (r < 50)
                act = ACT_HELLO;
            else if (r < 65)
                act = ACT_QUERY_ACTIVE;
            else if (r < 80)
                act = ACT_QUERY_CONTAINED;
            else if (r < 97)
                act = (r < 85) ? ACT_HELLO : ACT_TICK;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_SPARE_LO;
                    1:       act = ACT_SPARE_MID;
                    default: act = ACT_SPARE_HI;
                endcase
            end
            if ($urandom_range(0, 19) == 0)
                id = $urandom;
            else
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            queue_cmd(act, id, (n % 400 == 200));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
